@@ rtl/tilemap_layer_renderer_unit_macros.svh @@
// Assertion macros shared by the tile map renderer RTL.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef TILEMAP_LAYER_RENDERER_UNIT_MACROS_SVH
`define TILEMAP_LAYER_RENDERER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TLR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tile map renderer check failed");

// Next-cycle implication, checked outside reset
`define TLR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile map renderer check failed");

`endif

@@ rtl/tlr_pkg.sv @@
// Shared types and constants of the tile map layer renderer.
// No dependencies; used by tlr_div and tilemap_layer_renderer_unit.
`timescale 1ns / 1ps

package tlr_pkg;

    // Default sizes of the stores
    localparam int STORE_WIDTH_DEF  = 512;
    localparam int STORE_HEIGHT_DEF = 512;
    localparam int MAP_DEPTH_DEF    = 4096;
    localparam int PIXEL_BITS_DEF   = 32;

    // Stream and configuration widths
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    // Largest window edge in pixels
    localparam logic [9:0] WIN_MAX = 10'd512;

    // Divider operand widths
    localparam int DIV_N_W = 12;
    localparam int DIV_D_W = 9;

    typedef enum logic [1:0] {
        CMD_WRITE_PIXEL = 2'd0,
        CMD_WRITE_TILE  = 2'd1,
        CMD_RENDER      = 2'd2,
        CMD_READ_PIXEL  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_TILE_WIDTH       = 3'd0,
        CFG_TILE_HEIGHT      = 3'd1,
        CFG_MAP_COLUMNS      = 3'd2,
        CFG_MAP_ROWS         = 3'd3,
        CFG_PATTERN_ORIGIN_X = 3'd4,
        CFG_PATTERN_ORIGIN_Y = 3'd5,
        CFG_PATTERN_COLUMNS  = 3'd6
    } cfg_reg_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
        logic [DIV_D_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ rtl/tlr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the renderer.
// Depends on tlr_pkg for the request and response types.
`timescale 1ns / 1ps

module tlr_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  tlr_pkg::div_req_t req,
    output tlr_pkg::div_rsp_t rsp
);
    import tlr_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] quot_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quot_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Control: count down the quotient bits while busy, then flag done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_N_W-2:0], fits};
            rem_reg  <= fits ? DIV_D_W'(trial - {1'b0, dvs_reg}) : trial[DIV_D_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ rtl/tilemap_layer_renderer_unit.sv @@
// Writes load their result on acceptance; a pixel read loads it in S_READ.
// Render: four setup divides in the shared divider, then per window pixel the
// states S_MAP, S_TDIV (tile divide), S_SRC, S_FETCH and S_WRITE.
// One request at a time; results wait in an output register.
// rst_n sets control and configuration registers to defaults, not the stores.
`timescale 1ns / 1ps
`include "tilemap_layer_renderer_unit_macros.svh"

module tilemap_layer_renderer_unit #(
    parameter int STORE_WIDTH  = tlr_pkg::STORE_WIDTH_DEF,
    parameter int STORE_HEIGHT = tlr_pkg::STORE_HEIGHT_DEF,
    parameter int MAP_DEPTH    = tlr_pkg::MAP_DEPTH_DEF,
    parameter int PIXEL_BITS   = tlr_pkg::PIXEL_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pixel_x, pixel_y, pixel_data, tile_address, tile_number, view_x,
    // view_y, window_x, window_y, window_width, window_height, zero pad
    input  logic [tlr_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [tlr_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value
    output logic [tlr_pkg::M_TDATA_W-1:0]  m_tdata,
    // clipped
    output logic [tlr_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlr_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import tlr_pkg::*;

    localparam int PIX_DEPTH = STORE_WIDTH * STORE_HEIGHT;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_MAP   = 8'b0000_1000,
        S_TDIV  = 8'b0001_0000,
        S_SRC   = 8'b0010_0000,
        S_FETCH = 8'b0100_0000,
        S_WRITE = 8'b1000_0000
    } state_t;

    function automatic logic [PIX_AW-1:0] pix_addr(input logic [15:0] x,
                                                   input logic [15:0] y);
        logic [31:0] a;
        a = 32'(y) * 32'(STORE_WIDTH) + 32'(x);
        return a[PIX_AW-1:0];
    endfunction

    function automatic logic in_store(input logic [15:0] x, input logic [15:0] y);
        return (x < 16'(STORE_WIDTH)) && (y < 16'(STORE_HEIGHT));
    endfunction

    // Request fields
    logic [1:0]  in_cmd;
    logic [8:0]  in_px, in_py, in_wx, in_wy;
    logic [31:0] in_data;
    logic [11:0] in_taddr, in_scx, in_scy;
    logic [7:0]  in_tnum;
    logic [9:0]  in_ww, in_wh, ww_sat, wh_sat;
    logic        accept;

    assign in_cmd   = s_tuser;
    assign in_px    = s_tdata[8:0];
    assign in_py    = s_tdata[17:9];
    assign in_data  = s_tdata[49:18];
    assign in_taddr = s_tdata[61:50];
    assign in_tnum  = s_tdata[69:62];
    assign in_scx   = s_tdata[81:70];
    assign in_scy   = s_tdata[93:82];
    assign in_wx    = s_tdata[102:94];
    assign in_wy    = s_tdata[111:103];
    assign in_ww    = s_tdata[121:112];
    assign in_wh    = s_tdata[131:122];
    assign ww_sat   = (in_ww > WIN_MAX) ? WIN_MAX : in_ww;
    assign wh_sat   = (in_wh > WIN_MAX) ? WIN_MAX : in_wh;

    // Configuration registers
    logic [6:0] tile_width_reg, tile_height_reg, map_columns_reg, map_rows_reg;
    logic [8:0] pattern_origin_x_reg, pattern_origin_y_reg, pattern_columns_reg;
    logic [6:0] tw_c, th_c, mc_c, mr_c;
    logic [8:0] pc_c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg       <= 7'd8;
            tile_height_reg      <= 7'd8;
            map_columns_reg      <= 7'd32;
            map_rows_reg         <= 7'd32;
            pattern_origin_x_reg <= 9'd0;
            pattern_origin_y_reg <= 9'd0;
            pattern_columns_reg  <= 9'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TILE_WIDTH:       tile_width_reg       <= cfg_data[6:0];
                CFG_TILE_HEIGHT:      tile_height_reg      <= cfg_data[6:0];
                CFG_MAP_COLUMNS:      map_columns_reg      <= cfg_data[6:0];
                CFG_MAP_ROWS:         map_rows_reg         <= cfg_data[6:0];
                CFG_PATTERN_ORIGIN_X: pattern_origin_x_reg <= cfg_data;
                CFG_PATTERN_ORIGIN_Y: pattern_origin_y_reg <= cfg_data;
                CFG_PATTERN_COLUMNS:  pattern_columns_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate registers to their legal ranges
    assign tw_c = (tile_width_reg == 7'd0) ? 7'd1 :
                  (tile_width_reg > 7'd64) ? 7'd64 : tile_width_reg;
    assign th_c = (tile_height_reg == 7'd0) ? 7'd1 :
                  (tile_height_reg > 7'd64) ? 7'd64 : tile_height_reg;
    assign mc_c = (map_columns_reg == 7'd0) ? 7'd1 :
                  (map_columns_reg > 7'd64) ? 7'd64 : map_columns_reg;
    assign mr_c = (map_rows_reg == 7'd0) ? 7'd1 :
                  (map_rows_reg > 7'd64) ? 7'd64 : map_rows_reg;
    assign pc_c = (pattern_columns_reg == 9'd0) ? 9'd1 :
                  (pattern_columns_reg > 9'd256) ? 9'd256 : pattern_columns_reg;

    // Control and render state
    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg;
    logic       out_clip_reg;
    logic       div_run_reg;
    logic [1:0] step_reg;
    logic       clip_reg;
    logic [8:0] col_reg, row_reg;
    logic [5:0] offx0_reg, tx0_reg, offx_reg, tx_reg, offy_reg, ty_reg;
    logic [11:0] qtmp_reg;
    logic [11:0] scx_reg, scy_reg;
    logic [8:0] wx_reg, wy_reg;
    logic [9:0] ww_reg, wh_reg;
    logic [7:0] tq_reg, tr_reg;
    logic [15:0] sx_reg, sy_reg;

    // Memory side signals
    logic [PIXEL_BITS-1:0] pixel_mem [PIX_DEPTH];
    logic [7:0]            map_mem [MAP_DEPTH];
    logic [PIXEL_BITS-1:0] pix_rdata_reg;
    logic                  src_ok_reg;
    logic [7:0]            map_rdata_reg;
    logic                  map_ok_reg;
    logic                  pix_we, pix_re;
    logic [PIX_AW-1:0]     pix_waddr, pix_raddr;
    logic [PIXEL_BITS-1:0] pix_wdata;
    logic                  pix_rok;
    logic [16:0]           taddr_ext, idx_ext;
    logic [12:0]           idx;
    logic [15:0]           dx, dy;
    logic                  dest_ok, last_col, last_row;
    logic                  out_load, out_clip_in;
    logic [31:0]           out_value_in;
    logic [14:0]           prod_x, prod_y;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign taddr_ext = {5'd0, in_taddr};
    assign idx       = 13'(tx_reg) + ty_reg * mc_c;
    assign idx_ext   = {4'd0, idx};
    assign dx        = 16'(wx_reg) + 16'(col_reg);
    assign dy        = 16'(wy_reg) + 16'(row_reg);
    assign dest_ok   = in_store(dx, dy);
    assign last_col  = ({1'b0, col_reg} == ww_reg - 10'd1);
    assign last_row  = ({1'b0, row_reg} == wh_reg - 10'd1);
    assign prod_x    = tr_reg * tw_c;
    assign prod_y    = tq_reg * th_c;

    // Shared divider: setup divides, then one tile divide per pixel
    always_comb
    begin
        div_req.start    = ((state_reg == S_SETUP) || (state_reg == S_TDIV)) && !div_run_reg;
        div_req.dividend = {4'd0, (map_ok_reg ? map_rdata_reg : 8'd0)};
        div_req.divisor  = pc_c;
        if (state_reg == S_SETUP)
        begin
            case (step_reg)
                2'd0:
                begin
                    div_req.dividend = scx_reg;
                    div_req.divisor  = {2'd0, tw_c};
                end
                2'd1:
                begin
                    div_req.dividend = qtmp_reg;
                    div_req.divisor  = {2'd0, mc_c};
                end
                2'd2:
                begin
                    div_req.dividend = scy_reg;
                    div_req.divisor  = {2'd0, th_c};
                end
                default:
                begin
                    div_req.dividend = qtmp_reg;
                    div_req.divisor  = {2'd0, mr_c};
                end
            endcase
        end
    end

    tlr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Pixel store port selection
    always_comb
    begin
        pix_we    = 1'b0;
        pix_waddr = pix_addr(dx, dy);
        pix_wdata = src_ok_reg ? pix_rdata_reg : '0;
        pix_re    = 1'b0;
        pix_raddr = pix_addr(sx_reg, sy_reg);
        pix_rok   = in_store(sx_reg, sy_reg);
        if (accept && (in_cmd == CMD_WRITE_PIXEL))
        begin
            pix_we    = in_store(16'(in_px), 16'(in_py));
            pix_waddr = pix_addr(16'(in_px), 16'(in_py));
            pix_wdata = in_data[PIXEL_BITS-1:0];
        end
        else if (state_reg == S_WRITE)
        begin
            pix_we = dest_ok;
        end
        if (accept && (in_cmd == CMD_READ_PIXEL))
        begin
            pix_re    = 1'b1;
            pix_raddr = pix_addr(16'(in_px), 16'(in_py));
            pix_rok   = in_store(16'(in_px), 16'(in_py));
        end
        else if (state_reg == S_FETCH)
        begin
            pix_re = 1'b1;
        end
    end

    // Pixel store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pixel_mem[pix_waddr] <= pix_wdata;
        if (pix_re)
        begin
            pix_rdata_reg <= pixel_mem[pix_raddr];
            src_ok_reg    <= pix_rok;
        end
    end

    // Tile map: write on request, read once per render pixel
    always_ff @(posedge clk)
    begin
        if (accept && (in_cmd == CMD_WRITE_TILE) && (taddr_ext < 17'(MAP_DEPTH)))
            map_mem[taddr_ext[MAP_AW-1:0]] <= in_tnum;
        if (state_reg == S_MAP)
        begin
            map_rdata_reg <= map_mem[idx_ext[MAP_AW-1:0]];
            map_ok_reg    <= idx_ext < 17'(MAP_DEPTH);
        end
    end

    // Next state and result loading
    always_comb
    begin
        state_next   = state_reg;
        out_load     = 1'b0;
        out_value_in = 32'd0;
        out_clip_in  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        CMD_READ_PIXEL: state_next = S_READ;
                        CMD_RENDER:
                        begin
                            if ((ww_sat == 10'd0) || (wh_sat == 10'd0))
                                out_load = 1'b1;
                            else
                                state_next = S_SETUP;
                        end
                        default: out_load = 1'b1;
                    endcase
                end
            end
            S_READ:
            begin
                out_load     = 1'b1;
                out_value_in = src_ok_reg ? 32'(pix_rdata_reg) : 32'd0;
                state_next   = S_IDLE;
            end
            S_SETUP:
            begin
                if (div_rsp.done && (step_reg == 2'd3))
                    state_next = S_MAP;
            end
            S_MAP:   state_next = S_TDIV;
            S_TDIV:
            begin
                if (div_rsp.done)
                    state_next = S_SRC;
            end
            S_SRC:   state_next = S_FETCH;
            S_FETCH: state_next = S_WRITE;
            S_WRITE:
            begin
                if (last_col && last_row)
                begin
                    out_load    = 1'b1;
                    out_clip_in = clip_reg | !dest_ok;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_MAP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_run_reg   <= 1'b0;
            step_reg      <= 2'd0;
            clip_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (div_req.start)
                div_run_reg <= 1'b1;
            else if (div_rsp.done)
                div_run_reg <= 1'b0;
            if (accept)
            begin
                step_reg <= 2'd0;
                clip_reg <= 1'b0;
            end
            else if ((state_reg == S_SETUP) && div_rsp.done)
            begin
                step_reg <= step_reg + 2'd1;
            end
            else if (state_reg == S_WRITE)
            begin
                clip_reg <= clip_reg | !dest_ok;
            end
        end
    end

    // Render datapath: window walk, tile offsets and source coordinates
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scx_reg <= in_scx;
            scy_reg <= in_scy;
            wx_reg  <= in_wx;
            wy_reg  <= in_wy;
            ww_reg  <= ww_sat;
            wh_reg  <= wh_sat;
            col_reg <= 9'd0;
            row_reg <= 9'd0;
        end
        if ((state_reg == S_SETUP) && div_rsp.done)
        begin
            case (step_reg)
                2'd0:
                begin
                    offx0_reg <= div_rsp.rem[5:0];
                    qtmp_reg  <= div_rsp.quot;
                end
                2'd1:
                begin
                    tx0_reg  <= div_rsp.rem[5:0];
                    tx_reg   <= div_rsp.rem[5:0];
                    offx_reg <= offx0_reg;
                end
                2'd2:
                begin
                    offy_reg <= div_rsp.rem[5:0];
                    qtmp_reg <= div_rsp.quot;
                end
                default: ty_reg <= div_rsp.rem[5:0];
            endcase
        end
        if ((state_reg == S_TDIV) && div_rsp.done)
        begin
            tq_reg <= div_rsp.quot[7:0];
            tr_reg <= div_rsp.rem[7:0];
        end
        if (state_reg == S_SRC)
        begin
            sx_reg <= 16'(pattern_origin_x_reg) + 16'(prod_x) + 16'(offx_reg);
            sy_reg <= 16'(pattern_origin_y_reg) + 16'(prod_y) + 16'(offy_reg);
        end
        // Advance to the next window pixel in raster order
        if (state_reg == S_WRITE)
        begin
            if (last_col)
            begin
                col_reg  <= 9'd0;
                offx_reg <= offx0_reg;
                tx_reg   <= tx0_reg;
                row_reg  <= row_reg + 9'd1;
                if (7'(offy_reg) + 7'd1 == th_c)
                begin
                    offy_reg <= 6'd0;
                    ty_reg   <= (7'(ty_reg) + 7'd1 == mr_c) ? 6'd0 : ty_reg + 6'd1;
                end
                else
                begin
                    offy_reg <= offy_reg + 6'd1;
                end
            end
            else
            begin
                col_reg <= col_reg + 9'd1;
                if (7'(offx_reg) + 7'd1 == tw_c)
                begin
                    offx_reg <= 6'd0;
                    tx_reg   <= (7'(tx_reg) + 7'd1 == mc_c) ? 6'd0 : tx_reg + 6'd1;
                end
                else
                begin
                    offx_reg <= offx_reg + 6'd1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= out_value_in;
            out_clip_reg  <= out_clip_in;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_clip_reg;

    `TLR_ASSERT_NXT(a_read_goes_to_read, accept && (in_cmd == CMD_READ_PIXEL), state_reg == S_READ)
    `TLR_ASSERT_IMP(a_div_done_owned, div_rsp.done, div_run_reg)
    `TLR_ASSERT_IMP(a_render_out_empty, state_reg == S_MAP, !out_valid_reg)
    `TLR_ASSERT_IMP(a_ready_only_idle, s_tready, state_reg == S_IDLE)

endmodule
